[sv/apra_pkg.sv]
// Shared types and constants for the aligned page-run allocator.
package apra_pkg;

	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned WORD_SH   = 6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	localparam logic CMD_RESERVE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_CHECK = 8'b0000_0100,
		S_SRD   = 8'b0000_1000,
		S_SEV   = 8'b0001_0000,
		S_MRD   = 8'b0010_0000,
		S_MWR   = 8'b0100_0000,
		S_RESP  = 8'b1000_0000
	} apra_state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic eval;
		logic write;
		logic clear;
	} apra_cmd_t;

	typedef struct packed {
		logic bad;
		logic release_op;
		logic hit;
		logic beyond;
		logic run_done;
		logic clear_done;
	} apra_stat_t;

endpackage

[sv/apra_ctrl.sv]
// Controller state machine for the aligned page-run allocator.
module apra_ctrl import apra_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  apra_stat_t stat,
	output apra_cmd_t  cmd
);

	apra_state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.setup = 1'b1;
				if (stat.bad) state_d = S_RESP;
				else if (stat.release_op) state_d = S_MRD;
				else state_d = S_SRD;
			end
			S_SRD: state_d = S_SEV;
			S_SEV: begin
				cmd.eval = 1'b1;
				if (stat.hit) state_d = stat.beyond ? S_RESP : S_SRD;
				else state_d = stat.run_done ? S_MRD : S_SRD;
			end
			S_MRD: state_d = S_MWR;
			S_MWR: begin
				cmd.write = 1'b1;
				state_d   = stat.run_done ? S_RESP : S_MRD;
			end
			S_RESP: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

endmodule

[sv/apra_dp.sv]
// Datapath of the page allocator: bitmap memory, scan and mark registers.
module apra_dp import apra_pkg::*; #(
	parameter int unsigned PAGES           = 16384,
	parameter int unsigned MAP_WORDS       = 256,
	parameter int unsigned MAX_ALIGN_PAGES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  apra_cmd_t   cmd,
	output apra_stat_t  stat,
	input  logic        in_cmd,
	input  logic [14:0] in_count,
	input  logic [9:0]  in_align,
	input  logic [13:0] in_start,
	output logic [1:0]  res_status,
	output logic [13:0] res_index
);

	localparam int unsigned CW = $clog2(PAGES + MAX_ALIGN_PAGES + 65536);
	localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned XW = CW - WORD_SH;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	logic          cmd_q;
	logic [14:0]   count_q;
	logic [9:0]    align_q;
	logic [13:0]   start_q;
	logic [CW-1:0] cand_q, pos_q, end_q;
	logic [1:0]    status_q;
	logic [13:0]   index_q;
	logic [AW-1:0] clr_q;

	logic [CW-1:0] cnt, last, alm, align_ext, pos_next, u, new_cand;
	logic          ok_cnt, ok_align, rel_ok, in_map;
	logic [XW-1:0] wi;
	logic [AW-1:0] addr;
	logic [WORD_BITS-1:0] word, lo_mask, hi_mask, mask, hit, new_word;
	logic [WORD_SH-1:0]   bidx;

	assign cnt       = CW'(count_q);
	assign align_ext = CW'(align_q);
	assign alm       = align_ext - CW'(1);
	assign last      = CW'(PAGES) - cnt;

	assign ok_cnt   = (count_q != '0) && (cnt <= CW'(PAGES));
	assign ok_align = (align_q != '0) && ((align_q & (align_q - 10'd1)) == '0)
		&& (align_ext <= CW'(MAX_ALIGN_PAGES));
	assign rel_ok   = ok_cnt && (CW'(start_q) + cnt <= CW'(PAGES));

	assign wi     = pos_q[CW-1:WORD_SH];
	assign addr   = wi[AW-1:0];
	assign in_map = (wi < XW'(MAP_WORDS));
	assign word   = in_map ? rdata_q : '1;

	// Bits of the current word that fall inside [pos, end).
	assign lo_mask = '1 << pos_q[WORD_SH-1:0];
	assign hi_mask = (end_q[CW-1:WORD_SH] == wi)
		? ((WORD_BITS'(1) << end_q[WORD_SH-1:0]) - WORD_BITS'(1)) : '1;
	assign mask    = lo_mask & hi_mask;
	assign hit     = word & mask;

	always_comb begin
		bidx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hit[i]) bidx = WORD_SH'(i);
		end
	end

	assign u        = {wi, bidx};
	assign new_cand = (u & ~alm) + align_ext;
	assign pos_next = (pos_q | CW'(WORD_BITS - 1)) + CW'(1);
	assign new_word = cmd_q ? (rdata_q & ~mask) : (rdata_q | mask);

	assign stat.bad        = cmd_q ? !rel_ok : !(ok_cnt && ok_align);
	assign stat.release_op = (cmd_q == CMD_RELEASE);
	assign stat.hit        = (hit != '0);
	assign stat.beyond     = (new_cand > last);
	assign stat.run_done   = (pos_next >= end_q);
	assign stat.clear_done = (clr_q == AW'(MAP_WORDS - 1));

	always_ff @(posedge clk) begin
		if (cmd.clear) mem[clr_q] <= '0;
		else if (cmd.write && in_map) mem[addr] <= new_word;
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear) clr_q <= clr_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= in_cmd;
			count_q <= in_count;
			align_q <= in_align;
			start_q <= in_start;
		end
		if (cmd.setup) begin
			index_q <= '0;
			if (stat.bad) begin
				status_q <= ST_BAD;
			end else if (cmd_q == CMD_RELEASE) begin
				status_q <= ST_OK;
				pos_q    <= CW'(start_q);
				end_q    <= CW'(start_q) + cnt;
			end else begin
				cand_q <= '0;
				pos_q  <= '0;
				end_q  <= cnt;
			end
		end
		if (cmd.eval) begin
			if (stat.hit) begin
				if (stat.beyond) begin
					status_q <= ST_NOSPACE;
					index_q  <= '0;
				end else begin
					cand_q <= new_cand;
					pos_q  <= new_cand;
					end_q  <= new_cand + cnt;
				end
			end else if (stat.run_done) begin
				// Whole run is free: go back to its start and mark it.
				pos_q    <= cand_q;
				status_q <= ST_OK;
				index_q  <= cand_q[13:0];
			end else begin
				pos_q <= pos_next;
			end
		end
		if (cmd.write) pos_q <= pos_next;
	end

	assign res_status = status_q;
	assign res_index  = index_q;

endmodule

[sv/aligned_page_run_allocator.sv]
// Top level of the aligned page-run allocator: stream ports, controller and datapath.
// Each beat is loaded and checked; a bad request goes straight to the result beat. A reserve
// scans bitmap words, then marks the free run; a release clears its run. The registered bitmap
// read gives each word a read state before its scan or mark state. One item is in flight at a
// time; the next beat can be accepted in the cycle after the result beat. After reset a clearing
// pass zeroes the bitmap, one word a cycle, before the first beat is accepted.
module aligned_page_run_allocator import apra_pkg::*; #(
	parameter int unsigned PAGES           = 16384,
	parameter int unsigned MAP_WORDS       = 256,
	parameter int unsigned MAX_ALIGN_PAGES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // run_pages[14:0], align_step[24:15], start_page[38:25]
	input  logic [0:0]  s_tuser,  // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // run_base[13:0]
	output logic [1:0]  m_tuser   // status[1:0]
);

	apra_cmd_t   cmd;
	apra_stat_t  stat;
	logic [13:0] index;

	apra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	apra_dp #(
		.PAGES           (PAGES),
		.MAP_WORDS       (MAP_WORDS),
		.MAX_ALIGN_PAGES (MAX_ALIGN_PAGES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_cmd     (s_tuser[0]),
		.in_count   (s_tdata[14:0]),
		.in_align   (s_tdata[24:15]),
		.in_start   (s_tdata[38:25]),
		.res_status (m_tuser),
		.res_index  (index)
	);

	assign m_tdata = {2'b00, index};

endmodule
